>>> design/compass_heading_from_xy_macros.svh
// assertion macros for the compass heading block
`ifndef COMPASS_HEADING_FROM_XY_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_MACROS_SVH

// same-cycle implication
`define CHFXY_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define CHFXY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> design/chfxy_pkg.sv
// shared types, constants and arctangent table for the compass heading block
`default_nettype none

package chfxy_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;
   localparam int FIELD_W          = 16;
   localparam int FRAC_SHIFT       = 16;
   localparam int XY_W             = 35;
   localparam int Z_W              = 25;
   localparam int ATAN_W           = 21;
   localparam int ANGLE_SHIFT      = 8;
   localparam int SUM_W            = 27;
   localparam int DEG_W            = SUM_W - ANGLE_SHIFT;
   localparam int HEAD_W           = 16;

   localparam logic signed [Z_W-1:0]   HALF_TURN_Q8 = 25'sd4608000;
   localparam logic signed [SUM_W-1:0] ROUND_HALF   = 27'sd128;
   localparam logic signed [DEG_W-1:0] FULL_TURN    = 19'sd36000;
   localparam logic signed [DEG_W-1:0] TWO_TURNS    = 19'sd72000;
   localparam logic [HEAD_W-1:0]       FULL_TURN_U  = 16'd36000;
   localparam logic [FIELD_W-1:0]      DECL_RESET   = 16'd603;

   // round(atan(2^-i) in degrees * 25600)
   localparam logic [ATAN_W-1:0] ATAN_Q8 [TABLE_LEN] = '{
      21'd1152000, 21'd680065, 21'd359328, 21'd182400,
      21'd91554,   21'd45822,  21'd22916,  21'd11459,
      21'd5730,    21'd2865,   21'd1432,   21'd716,
      21'd358,     21'd179,    21'd90,     21'd45,
      21'd22,      21'd11,     21'd6,      21'd3,
      21'd1,       21'd1,      21'd0,      21'd0
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } cordic_type;

endpackage

`default_nettype wire

>>> design/chfxy_cell.sv
// one vectoring cordic iteration with its pipeline register
`default_nettype none

module chfxy_cell
   import chfxy_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic       in_valid,
   input  wire cordic_type in_data,
   output logic            out_valid,
   output cordic_type      out_data
);

   logic signed [XY_W-1:0] x_cur;
   logic signed [XY_W-1:0] y_cur;
   logic signed [XY_W-1:0] x_sh;
   logic signed [XY_W-1:0] y_sh;
   logic signed [Z_W-1:0]  z_cur;
   logic signed [Z_W-1:0]  step_angle;
   logic                   y_pos;

   logic       valid_ff;
   logic       valid_in;
   cordic_type data_ff;
   cordic_type data_in;

   assign x_cur      = in_data.x;
   assign y_cur      = in_data.y;
   assign z_cur      = in_data.z;
   assign x_sh       = x_cur >>> STAGE;
   assign y_sh       = y_cur >>> STAGE;
   assign step_angle = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_Q8[STAGE]});
   assign y_pos      = !y_cur[XY_W-1] && (y_cur != '0);

   always_comb begin
      data_in.zero = in_data.zero;
      if (y_pos) begin
         data_in.x = x_cur + y_sh;
         data_in.y = y_cur - x_sh;
         data_in.z = z_cur + step_angle;
      end else begin
         data_in.x = x_cur - y_sh;
         data_in.y = y_cur + x_sh;
         data_in.z = z_cur - step_angle;
      end
   end

   assign valid_in = en ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> design/compass_heading_from_xy.sv
// Compass heading from a signed x/y field sample: a pipelined vectoring cordic
// (one cell per iteration) gives atan2(y, x), the declination register is added,
// and the sum is rounded and wrapped to 0..35999 hundredths of a degree. One item
// is taken every clock while the skid entry is empty, and it passes the input
// register, the cordic cells, the declination/round stage and the output
// register in turn. A two-entry output buffer keeps the input side accepting while a
// result waits. The declination port is always ready and resets to 6.03 degrees.
`default_nettype none

`include "compass_heading_from_xy_macros.svh"

module compass_heading_from_xy
   import chfxy_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [31:0]       req_tdata,   // field_x [15:0], field_y [31:16]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [HEAD_W-1:0]      rsp_tdata,   // heading_centideg [15:0]
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [FIELD_W-1:0] csr_data    // declination_centideg [15:0]
);

   logic                      adv;
   logic                      accept;
   logic signed [FIELD_W-1:0] field_x;
   logic signed [FIELD_W-1:0] field_y;
   logic signed [XY_W-1:0]    scaled_x;
   logic signed [XY_W-1:0]    scaled_y;

   logic       pre_valid_ff;
   logic       pre_valid_in;
   cordic_type pre_ff;
   cordic_type pre_in;

   cordic_type chain_data  [CORDIC_STEPS+1];
   logic       chain_valid [CORDIC_STEPS+1];

   logic [FIELD_W-1:0] decl_ff;
   logic [FIELD_W-1:0] decl_in;

   cordic_type              last;
   logic signed [Z_W-1:0]   z_eff;
   logic signed [SUM_W-1:0] decl_q8;
   logic signed [SUM_W-1:0] angle_sum;
   logic signed [SUM_W-1:0] angle_rnd;

   logic                    sum_valid_ff;
   logic                    sum_valid_in;
   logic signed [DEG_W-1:0] sum_ff;
   logic signed [DEG_W-1:0] sum_in;

   logic signed [DEG_W-1:0] wrapped;
   logic [HEAD_W-1:0]       heading;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [HEAD_W-1:0] out_data_ff;
   logic [HEAD_W-1:0] out_data_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   logic [HEAD_W-1:0] skid_data_ff;
   logic [HEAD_W-1:0] skid_data_in;

   // pipeline moves whenever the output buffer has room
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // input stage: scale and fold the left half plane
   assign field_x  = req_tdata[FIELD_W-1:0];
   assign field_y  = req_tdata[2*FIELD_W-1:FIELD_W];
   assign scaled_x = {{(XY_W-FIELD_W-FRAC_SHIFT){field_x[FIELD_W-1]}}, field_x,
                      {FRAC_SHIFT{1'b0}}};
   assign scaled_y = {{(XY_W-FIELD_W-FRAC_SHIFT){field_y[FIELD_W-1]}}, field_y,
                      {FRAC_SHIFT{1'b0}}};

   always_comb begin
      pre_in.zero = (field_x == '0) && (field_y == '0);
      if (field_x[FIELD_W-1]) begin
         pre_in.x = -scaled_x;
         pre_in.y = -scaled_y;
         pre_in.z = HALF_TURN_Q8;
      end else begin
         pre_in.x = scaled_x;
         pre_in.y = scaled_y;
         pre_in.z = '0;
      end
   end

   assign pre_valid_in = adv ? accept : pre_valid_ff;

   // cordic cells
   assign chain_data[0]  = pre_ff;
   assign chain_valid[0] = pre_valid_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      chfxy_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // declination add and rounding to whole hundredths
   assign decl_in   = (csr_valid && csr_ready) ? csr_data : decl_ff;
   assign last      = chain_data[CORDIC_STEPS];
   assign z_eff     = last.zero ? '0 : last.z;
   assign decl_q8   = {{(SUM_W-FIELD_W-ANGLE_SHIFT){decl_ff[FIELD_W-1]}}, decl_ff,
                       {ANGLE_SHIFT{1'b0}}};
   assign angle_sum = {{(SUM_W-Z_W){z_eff[Z_W-1]}}, z_eff} + decl_q8;
   assign angle_rnd = angle_sum + ROUND_HALF;
   assign sum_in    = angle_rnd[SUM_W-1:ANGLE_SHIFT];

   assign sum_valid_in = adv ? chain_valid[CORDIC_STEPS] : sum_valid_ff;

   // wrap into one full turn
   always_comb begin
      if (sum_ff < -FULL_TURN) begin
         wrapped = sum_ff + TWO_TURNS;
      end else if (sum_ff < 0) begin
         wrapped = sum_ff + FULL_TURN;
      end else if (sum_ff >= FULL_TURN) begin
         wrapped = sum_ff - FULL_TURN;
      end else begin
         wrapped = sum_ff;
      end
   end

   assign heading = wrapped[HEAD_W-1:0];

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_in = sum_valid_ff;
         out_data_in  = heading;
      end else if (sum_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff  <= 1'b0;
         sum_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         decl_ff       <= DECL_RESET;
      end else begin
         pre_valid_ff  <= pre_valid_in;
         sum_valid_ff  <= sum_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         decl_ff       <= decl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff <= pre_in;
         sum_ff <= sum_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `CHFXY_ASSERT_IMPLIES(a_heading_range, clock, reset, rsp_tvalid, rsp_tdata < FULL_TURN_U)
   `CHFXY_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CHFXY_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp_tready, skid_valid_ff)
   `CHFXY_ASSERT_NEXT(a_accept_enters, clock, reset, accept, pre_valid_ff)

endmodule

`default_nettype wire
